@@ rtl/core/prq_pkg.sv @@
`default_nettype none

package prq_pkg;

  localparam int unsigned TID_W    = 6;
  localparam int unsigned PRIO_W   = 5;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_READY   = 2'd0,
    KIND_YIELD   = 2'd1,
    KIND_PREEMPT = 2'd2,
    KIND_BLOCK   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_IDLE_MISUSE = 2'd1,
    ST_DUPLICATE   = 2'd2
  } status_e;

  localparam logic [TID_W-1:0]  IDLE_TID  = '0;
  localparam logic [PRIO_W-1:0] IDLE_PRIO = '0;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_ENQ_RD  = 8'b0000_0100,
    S_ENQ_WR  = 8'b0000_1000,
    S_PICK_RD = 8'b0001_0000,
    S_PICK_HD = 8'b0010_0000,
    S_PICK_WR = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic enq_rd;
    logic enq_wr;
    logic pick_rd;
    logic pick_hd;
    logic pick_wr;
    logic load_result;
  } prq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  item_ok;
    logic  preempt_go;
    logic  pick_more;
    logic  out_free;
  } prq_sts_t;

  // Head and tail of one level's ready queue
  typedef struct packed {
    logic [TID_W-1:0] head;
    logic [TID_W-1:0] tail;
  } prq_ht_t;

endpackage

`default_nettype wire

@@ rtl/core/prq_if.sv @@
`default_nettype none

interface prq_in_if;
  logic                            valid;
  logic                            ready;
  prq_pkg::kind_e                  kind;
  logic [prq_pkg::TID_W-1:0]       thread_id;
  logic [prq_pkg::PRIO_W-1:0]      priority_req;

  modport source (output valid, output kind, output thread_id, output priority_req,
                  input ready);
  modport sink   (input valid, input kind, input thread_id, input priority_req,
                  output ready);
endinterface

interface prq_out_if;
  logic                            valid;
  logic                            ready;
  logic [prq_pkg::TID_W-1:0]       running_thread;
  logic [prq_pkg::PRIO_W-1:0]      running_priority;
  logic                            switched;
  logic [prq_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output running_thread, output running_priority,
                  output switched, output status, input ready);
  modport sink   (input valid, input running_thread, input running_priority,
                  input switched, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/prq_ctrl.sv @@
`default_nettype none

module prq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire prq_pkg::prq_sts_t sts_i,
  output prq_pkg::prq_cmd_t      cmd_o
);

  prq_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == prq_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      prq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = prq_pkg::S_DECODE;
        end
      end
      prq_pkg::S_DECODE: begin
        cmd_o.decode = 1'b1;
        case (sts_i.kind)
          prq_pkg::KIND_READY,
          prq_pkg::KIND_YIELD:   state_d = sts_i.item_ok ? prq_pkg::S_ENQ_RD : prq_pkg::S_FIN;
          prq_pkg::KIND_PREEMPT: state_d = sts_i.preempt_go ? prq_pkg::S_ENQ_RD
                                                             : prq_pkg::S_FIN;
          default:               state_d = prq_pkg::S_PICK_RD;
        endcase
      end
      prq_pkg::S_ENQ_RD: begin
        cmd_o.enq_rd = 1'b1;
        state_d      = prq_pkg::S_ENQ_WR;
      end
      prq_pkg::S_ENQ_WR: begin
        cmd_o.enq_wr = 1'b1;
        // a ready item only queues; the others requeue and then pick
        state_d = (sts_i.kind == prq_pkg::KIND_READY) ? prq_pkg::S_FIN : prq_pkg::S_PICK_RD;
      end
      prq_pkg::S_PICK_RD: begin
        cmd_o.pick_rd = 1'b1;
        state_d       = prq_pkg::S_PICK_HD;
      end
      prq_pkg::S_PICK_HD: begin
        cmd_o.pick_hd = 1'b1;
        state_d       = sts_i.pick_more ? prq_pkg::S_PICK_WR : prq_pkg::S_FIN;
      end
      prq_pkg::S_PICK_WR: begin
        cmd_o.pick_wr = 1'b1;
        state_d       = prq_pkg::S_FIN;
      end
      prq_pkg::S_FIN: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = prq_pkg::S_IDLE;
        end
      end
      default: state_d = prq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/prq_dp.sv @@
`default_nettype none

module prq_dp #(
  parameter int unsigned MAX_THREADS     = 64,
  parameter int unsigned PRIORITY_LEVELS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire prq_pkg::prq_cmd_t             cmd_i,
  input  wire prq_pkg::kind_e                kind_i,
  input  wire logic [prq_pkg::TID_W-1:0]     thread_id_i,
  input  wire logic [prq_pkg::PRIO_W-1:0]    priority_req_i,
  input  wire logic                          out_ready_i,
  output prq_pkg::prq_sts_t                  sts_o,
  output logic                               out_valid_o,
  output logic [prq_pkg::TID_W-1:0]          running_thread_o,
  output logic [prq_pkg::PRIO_W-1:0]         running_priority_o,
  output logic                               switched_o,
  output logic [prq_pkg::STATUS_W-1:0]       status_o
);

  localparam int unsigned IDX_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned LVL_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(PRIORITY_LEVELS - 1);

  typedef logic [prq_pkg::TID_W-1:0] tid_t;
  typedef logic [LVL_W-1:0]          lvl_t;

  // Highest non-empty level; zero when the bitmap is empty
  function automatic lvl_t top_level(input logic [PRIORITY_LEVELS-1:0] bits);
    lvl_t lv;
    lv = '0;
    for (int i = 0; i < int'(PRIORITY_LEVELS); i++) begin
      if (bits[i]) lv = lvl_t'(i);
    end
    return lv;
  endfunction

  // Queue memories
  prq_pkg::prq_ht_t ht_mem   [PRIORITY_LEVELS];
  tid_t             link_mem [MAX_THREADS];
  prq_pkg::prq_ht_t ht_rd_q;
  tid_t             link_rd_q;

  logic [PRIORITY_LEVELS-1:0] bitmap_q;
  logic [MAX_THREADS-1:0]     queued_q;
  tid_t                       cur_tid_q;
  logic [prq_pkg::PRIO_W-1:0] cur_prio_q;

  // Item and working registers
  prq_pkg::kind_e   kind_q;
  tid_t             tid_q;
  lvl_t             lvl_q;
  tid_t             before_q;
  prq_pkg::status_e status_q;
  tid_t             enq_tid_q;
  lvl_t             enq_lvl_q;
  lvl_t             pick_lvl_q;
  logic             pick_none_q;

  logic             out_valid_q;
  tid_t             out_tid_q;
  logic [prq_pkg::PRIO_W-1:0] out_prio_q;
  logic             out_sw_q;
  prq_pkg::status_e out_st_q;

  lvl_t             top_lvl;
  lvl_t             sat_lvl;
  logic             tid_range_bad;
  prq_pkg::status_e dec_status;
  logic             preempt_go;

  assign top_lvl = top_level(bitmap_q);

  always_comb begin
    if (32'(priority_req_i) >= PRIORITY_LEVELS) begin
      sat_lvl = TOP_LVL;
    end else begin
      sat_lvl = lvl_t'(priority_req_i);
    end
  end

  assign tid_range_bad = (tid_q == prq_pkg::IDLE_TID) || (32'(tid_q) >= MAX_THREADS);

  always_comb begin
    dec_status = prq_pkg::ST_OK;
    case (kind_q)
      prq_pkg::KIND_READY: begin
        if (tid_range_bad) begin
          dec_status = prq_pkg::ST_IDLE_MISUSE;
        end else if (queued_q[IDX_W'(tid_q)] || (tid_q == cur_tid_q)) begin
          dec_status = prq_pkg::ST_DUPLICATE;
        end
      end
      prq_pkg::KIND_YIELD: begin
        if (cur_tid_q == prq_pkg::IDLE_TID) dec_status = prq_pkg::ST_IDLE_MISUSE;
      end
      default: dec_status = prq_pkg::ST_OK;
    endcase
  end

  assign preempt_go = (cur_tid_q != prq_pkg::IDLE_TID) && (|bitmap_q)
                      && (prq_pkg::PRIO_W'(top_lvl) >= cur_prio_q);

  assign sts_o.kind       = kind_q;
  assign sts_o.item_ok    = (dec_status == prq_pkg::ST_OK);
  assign sts_o.preempt_go = preempt_go;
  assign sts_o.pick_more  = !pick_none_q && (ht_rd_q.head != ht_rd_q.tail);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Item capture and decode
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      tid_q    <= thread_id_i;
      lvl_q    <= sat_lvl;
      before_q <= cur_tid_q;
    end
    if (cmd_i.decode) begin
      status_q <= dec_status;
      if (kind_q == prq_pkg::KIND_READY) begin
        enq_tid_q <= tid_q;
        enq_lvl_q <= lvl_q;
      end else begin
        enq_tid_q <= cur_tid_q;
        enq_lvl_q <= lvl_t'(cur_prio_q);
      end
    end
    if (cmd_i.pick_rd) begin
      pick_lvl_q  <= top_lvl;
      pick_none_q <= ~|bitmap_q;
    end
  end

  // Head/tail memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_rd) begin
      ht_rd_q <= ht_mem[enq_lvl_q];
    end else if (cmd_i.pick_rd) begin
      ht_rd_q <= ht_mem[top_lvl];
    end
    if (cmd_i.enq_wr) begin
      if (bitmap_q[enq_lvl_q]) begin
        ht_mem[enq_lvl_q] <= '{head: ht_rd_q.head, tail: enq_tid_q};
      end else begin
        ht_mem[enq_lvl_q] <= '{head: enq_tid_q, tail: enq_tid_q};
      end
    end else if (cmd_i.pick_wr) begin
      ht_mem[pick_lvl_q] <= '{head: link_rd_q, tail: ht_rd_q.tail};
    end
  end

  // Link memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_wr && bitmap_q[enq_lvl_q]) begin
      link_mem[IDX_W'(ht_rd_q.tail)] <= enq_tid_q;
    end
    if (cmd_i.pick_hd) begin
      link_rd_q <= link_mem[IDX_W'(ht_rd_q.head)];
    end
  end

  // Bitmap, queued flags and running thread
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q   <= '0;
      queued_q   <= '0;
      cur_tid_q  <= prq_pkg::IDLE_TID;
      cur_prio_q <= prq_pkg::IDLE_PRIO;
    end else begin
      if (cmd_i.enq_wr) begin
        bitmap_q[enq_lvl_q]          <= 1'b1;
        queued_q[IDX_W'(enq_tid_q)] <= 1'b1;
      end
      if (cmd_i.pick_hd) begin
        if (pick_none_q) begin
          cur_tid_q  <= prq_pkg::IDLE_TID;
          cur_prio_q <= prq_pkg::IDLE_PRIO;
        end else begin
          cur_tid_q  <= ht_rd_q.head;
          cur_prio_q <= prq_pkg::PRIO_W'(pick_lvl_q);
          queued_q[IDX_W'(ht_rd_q.head)] <= 1'b0;
          // last entry of the level leaves: mark it empty
          if (ht_rd_q.head == ht_rd_q.tail) bitmap_q[pick_lvl_q] <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_tid_q  <= cur_tid_q;
      out_prio_q <= cur_prio_q;
      out_sw_q   <= (cur_tid_q != before_q);
      out_st_q   <= status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign running_thread_o   = out_tid_q;
  assign running_priority_o = out_prio_q;
  assign switched_o         = out_sw_q;
  assign status_o           = out_st_q;

endmodule

`default_nettype wire

@@ rtl/core/priority_ready_queue_scheduler.sv @@
`default_nettype none
// Thread scheduler with one FIFO ready queue per priority level and a
// bitmap of non-empty levels. Thread 0 is the idle thread.
// Input channel in_i carries kind, thread_id and priority_req; output
// channel out_o returns one item per input: running_thread,
// running_priority, switched and status. Both use valid/ready.
// One item is in work at a time; in_i.ready is high only while the
// sequencer is idle. Each item is decoded; then, as the event needs,
// a level's head/tail entry is read and written to enqueue, and the top
// level's head/tail and its head's link are read, and head/tail written
// back while entries remain, to pick. Rejected items and preempt ticks
// without switch skip both. Idle is reached again before the next item.
// A finished result waits in the output register while out_o.ready is
// low; the sequencer holds its last step until the register frees.
// Reset empties every level, clears the queued flags and leaves the idle
// thread running at priority 0; the queue memories need no clearing.
module priority_ready_queue_scheduler #(
  parameter int unsigned MAX_THREADS     = 64,
  parameter int unsigned PRIORITY_LEVELS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prq_in_if.sink     in_i,
  prq_out_if.source  out_o
);

  prq_pkg::prq_cmd_t cmd;
  prq_pkg::prq_sts_t sts;

  prq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prq_dp #(
    .MAX_THREADS     (MAX_THREADS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .kind_i             (in_i.kind),
    .thread_id_i        (in_i.thread_id),
    .priority_req_i     (in_i.priority_req),
    .out_ready_i        (out_o.ready),
    .sts_o              (sts),
    .out_valid_o        (out_o.valid),
    .running_thread_o   (out_o.running_thread),
    .running_priority_o (out_o.running_priority),
    .switched_o         (out_o.switched),
    .status_o           (out_o.status)
  );

endmodule

`default_nettype wire

@@ rtl/core/prq_chk.sv @@
`default_nettype none

module prq_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [prq_pkg::TID_W-1:0]      running_thread_i,
  input wire logic [prq_pkg::PRIO_W-1:0]     running_priority_i,
  input wire logic                           switched_i,
  input wire logic [prq_pkg::STATUS_W-1:0]   status_i
);

  // One item at a time: no acceptance in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken twice in a row");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(running_thread_i) && $stable(status_i)))
    else $error("stalled result changed");

  // Idle thread always runs at priority zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (running_thread_i == prq_pkg::IDLE_TID)) |->
      (running_priority_i == prq_pkg::IDLE_PRIO))
    else $error("idle thread with non-zero priority");

  // An ignored item never switches threads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != prq_pkg::ST_OK)) |-> !switched_i)
    else $error("switch reported on an ignored item");

endmodule

bind priority_ready_queue_scheduler prq_chk u_prq_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .running_thread_i   (out_o.running_thread),
  .running_priority_i (out_o.running_priority),
  .switched_i         (out_o.switched),
  .status_i           (out_o.status)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import prq_pkg::*;

  localparam int unsigned N_LEVELS  = 32;
  localparam int unsigned N_THREADS = 64;
  localparam int unsigned PHASE_LEN = 300;

  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    logic              switched;
    status_e           status;
  } sched_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  prq_in_if  in_if ();
  prq_out_if out_if ();

  priority_ready_queue_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scheduler mirror: one FIFO per level, queued flags, running thread
  logic [TID_W-1:0]  level_fifo [N_LEVELS][$];
  logic [N_THREADS-1:0] is_queued = '0;
  logic [TID_W-1:0]  run_tid  = IDLE_TID;
  logic [PRIO_W-1:0] run_prio = IDLE_PRIO;

  sched_result_t schedule_q [$];

  int  err_count    = 0;
  int  sent_count   = 0;
  int  result_count = 0;
  int  switch_count = 0;
  int  dup_count    = 0;
  int  misuse_count = 0;
  logic calm = 1'b0;

  function automatic int highest_level();
    for (int lv = N_LEVELS - 1; lv >= 0; lv--) begin
      if (level_fifo[lv].size() != 0) return lv;
    end
    return -1;
  endfunction

  function automatic void requeue(logic [TID_W-1:0] tid, logic [PRIO_W-1:0] lv);
    level_fifo[lv].push_back(tid);
    is_queued[tid] = 1'b1;
  endfunction

  function automatic void dispatch_next();
    int lv;
    lv = highest_level();
    if (lv < 0) begin
      run_tid  = IDLE_TID;
      run_prio = IDLE_PRIO;
    end else begin
      run_tid  = level_fifo[lv].pop_front();
      run_prio = lv[PRIO_W-1:0];
      is_queued[run_tid] = 1'b0;
    end
  endfunction

  function automatic sched_result_t predict_schedule(kind_e k, logic [TID_W-1:0] tid,
                                                     logic [PRIO_W-1:0] prio);
    sched_result_t res;
    logic [TID_W-1:0] prev;
    int lv;
    prev = run_tid;
    res.status = ST_OK;
    case (k)
      KIND_READY: begin
        if (tid == IDLE_TID) res.status = ST_IDLE_MISUSE;
        else if (is_queued[tid] || tid == run_tid) res.status = ST_DUPLICATE;
        else requeue(tid, prio);
      end
      KIND_YIELD: begin
        if (run_tid == IDLE_TID) begin
          res.status = ST_IDLE_MISUSE;
        end else begin
          requeue(run_tid, run_prio);
          dispatch_next();
        end
      end
      KIND_PREEMPT: begin
        lv = highest_level();
        if (run_tid != IDLE_TID && lv >= 0 && lv >= int'(run_prio)) begin
          requeue(run_tid, run_prio);
          dispatch_next();
        end
      end
      default: dispatch_next();
    endcase
    res.tid      = run_tid;
    res.prio     = run_prio;
    res.switched = (run_tid != prev);
    return res;
  endfunction

  task automatic send_item(kind_e k, logic [TID_W-1:0] tid, logic [PRIO_W-1:0] prio);
    if (!calm && $urandom_range(99) < 18) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= k;
    in_if.thread_id    <= tid;
    in_if.priority_req <= prio;
    do @(posedge clk_i); while (!in_if.ready);
    schedule_q.push_back(predict_schedule(k, tid, prio));
    sent_count++;
  endtask

  // Hold off the sender until every expected item has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (schedule_q.size() != 0);
  endtask

  task automatic report_mismatch(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    err_count++;
  endtask

  task automatic test_idle_cases();
    send_item(KIND_BLOCK,   IDLE_TID, '0);
    send_item(KIND_PREEMPT, IDLE_TID, '0);
    send_item(KIND_YIELD,   IDLE_TID, '0);
    send_item(KIND_READY,   IDLE_TID, 5'd5);
  endtask

  task automatic test_priority_extremes();
    send_item(KIND_READY,   6'd63, 5'd31);
    send_item(KIND_READY,   6'd1,  5'd0);
    send_item(KIND_READY,   6'd1,  5'd0);
    send_item(KIND_BLOCK,   6'd0,  5'd0);
    send_item(KIND_READY,   6'd63, 5'd31);
    send_item(KIND_PREEMPT, 6'd0,  5'd0);
    // Sole thread at its level: yield picks it again
    send_item(KIND_YIELD,   6'd0,  5'd0);
    send_item(KIND_BLOCK,   6'd0,  5'd0);
    send_item(KIND_PREEMPT, 6'd0,  5'd0);
    send_item(KIND_BLOCK,   6'd0,  5'd0);
  endtask

  task automatic test_round_robin();
    send_item(KIND_READY,   6'd5, 5'd7);
    send_item(KIND_READY,   6'd6, 5'd7);
    send_item(KIND_READY,   6'd7, 5'd7);
    send_item(KIND_BLOCK,   6'd0, 5'd0);
    send_item(KIND_PREEMPT, 6'd0, 5'd0);
    send_item(KIND_YIELD,   6'd0, 5'd0);
    send_item(KIND_PREEMPT, 6'd0, 5'd0);
    send_item(KIND_READY,   6'd9, 5'd12);
    send_item(KIND_PREEMPT, 6'd0, 5'd0);
    send_item(KIND_BLOCK,   6'd0, 5'd0);
  endtask

  task automatic test_random_traffic();
    int r;
    int lim_ready;
    kind_e k;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    for (int phase = 0; phase < 3; phase++) begin
      calm = (phase == 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Favour blocks once many threads wait, so the queues stay bounded
        lim_ready = ($countones(is_queued) > 20) ? 25 : 50;
        r = $urandom_range(99);
        if (r < lim_ready) k = KIND_READY;
        else if (r < lim_ready + 18) k = KIND_YIELD;
        else if (r < lim_ready + 38) k = KIND_PREEMPT;
        else k = KIND_BLOCK;

        r = $urandom_range(99);
        if (r < 40) prio = PRIO_W'($urandom_range(2, 4));
        else if (r < 50) prio = ($urandom_range(1) != 0) ? 5'd31 : 5'd0;
        else prio = PRIO_W'($urandom_range(31));

        tid = TID_W'($urandom_range(1, 63));
        if ($urandom_range(99) < 88) begin
          for (int tries = 0; tries < 8 && (is_queued[tid] || tid == run_tid); tries++)
            tid = TID_W'($urandom_range(1, 63));
        end else begin
          tid = TID_W'($urandom_range(63));
        end
        send_item(k, tid, prio);
      end
      drain();
    end
    calm = 1'b0;
  endtask

  // Result side: random backpressure and the comparison against the mirror
  initial begin
    sched_result_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        result_count++;
        if (schedule_q.size() == 0) begin
          $display("%0t: unexpected item, actual thread %0d priority %0d", $time,
                   out_if.running_thread, out_if.running_priority);
          err_count++;
        end else begin
          want = schedule_q.pop_front();
          if (out_if.running_thread !== want.tid)
            report_mismatch("running_thread", want.tid, out_if.running_thread);
          if (out_if.running_priority !== want.prio)
            report_mismatch("running_priority", want.prio, out_if.running_priority);
          if (out_if.switched !== want.switched)
            report_mismatch("switched", want.switched, out_if.switched);
          if (out_if.status !== want.status)
            report_mismatch("status", want.status, out_if.status);
          if (want.switched) switch_count++;
          if (want.status == ST_DUPLICATE) dup_count++;
          if (want.status == ST_IDLE_MISUSE) misuse_count++;
        end
      end
      out_if.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  initial begin
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_READY;
    in_if.thread_id    <= '0;
    in_if.priority_req <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_cases();
    test_priority_extremes();
    drain();
    test_round_robin();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk_i);
    if (schedule_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, schedule_q.size());
      err_count++;
    end
    $display("Sent %0d items, checked %0d results: %0d thread switches,", sent_count,
             result_count, switch_count);
    $display("  %0d duplicate-ready and %0d idle-misuse rejections, %0d mismatches",
             dup_count, misuse_count, err_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/prq_pkg.sv
rtl/core/prq_if.sv
rtl/core/prq_ctrl.sv
rtl/core/prq_dp.sv
rtl/core/priority_ready_queue_scheduler.sv
rtl/core/prq_chk.sv
sim/tb_top.sv
